/* rtl/sida_pkg.sv */
// shared constants and helpers for the signed integer to decimal ascii converter
package sida_pkg;

  localparam int CodeW = 7;

  localparam logic [CodeW-1:0] CODE_ZERO  = 7'd48;
  localparam logic [CodeW-1:0] CODE_MINUS = 7'd45;

  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

  // decimal digits of 2^(w-1), the largest magnitude; log10(2) ~ 0.30103
  function automatic int digit_count(input int w);
    return ((w - 1) * 30103) / 100000 + 1;
  endfunction

endpackage

/* rtl/signed_int_to_decimal_ascii.sv */
// top level: signed integer to decimal ascii text, one character per transfer
// Input channel: in_value with in_valid/in_stall; a transfer happens on a clock
// edge with in_valid high and in_stall low. Each value yields its decimal text
// on the output channel, most significant character first: a leading minus for
// negative values, no leading zeros, a single '0' for zero. out_last_char marks
// the final character; the most negative value converts correctly.
// Path from input transfer to first character: input register, VALUE_WIDTH
// shift-and-add-3 stages, serializer, output register. Throughput: one
// character per cycle on the output while out_stall is low; a value has up to
// 11 characters at a width of 32, and the serializer is the bottleneck: the
// bcd pipeline accepts a value every cycle unless it is backed up.
// out_stall holds the output register; the serializer and then each pipeline
// stage back up in turn and in_stall rises only when the whole pipeline is full.
// Nothing is dropped or repeated. Synchronous active-low reset empties all
// stages; no configuration is needed.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [sida_pkg::CodeW-1:0] out_char_code,
  output logic                   out_last_char
);

  localparam int NDig = sida_pkg::digit_count(VALUE_WIDTH);
  localparam int BcdW = NDig * 4;

  // input register: sign and unsigned magnitude
  logic                   s0_valid_r, s0_valid_nxt;
  logic                   s0_neg_r;
  logic [VALUE_WIDTH-1:0] s0_mag_r;
  logic                   s0_advance;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;

  // stage chain: index i feeds dabble stage i, index VALUE_WIDTH feeds serializer
  logic                   ch_valid [0:VALUE_WIDTH];
  logic                   ch_ready [0:VALUE_WIDTH];
  logic                   ch_neg   [0:VALUE_WIDTH];
  logic [VALUE_WIDTH-1:0] ch_mag   [0:VALUE_WIDTH];
  logic [BcdW-1:0]        ch_bcd   [0:VALUE_WIDTH];

  // magnitude as unsigned, so the most negative value does not overflow
  assign in_neg = in_value[VALUE_WIDTH-1];
  assign in_mag = in_neg ? VALUE_WIDTH'(~in_value + 1'b1) : VALUE_WIDTH'(in_value);

  assign s0_advance = !s0_valid_r || ch_ready[0];
  assign in_stall   = !s0_advance;

  always_comb begin
    s0_valid_nxt = s0_advance ? in_valid : s0_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_advance && in_valid) begin
      s0_neg_r <= in_neg;
      s0_mag_r <= in_mag;
    end
  end

  assign ch_valid[0] = s0_valid_r;
  assign ch_neg[0]   = s0_neg_r;
  assign ch_mag[0]   = s0_mag_r;
  assign ch_bcd[0]   = '0;

  // one magnitude bit shifted into the bcd digits per stage
  for (genvar g = 0; g < VALUE_WIDTH; g++) begin : g_dabble
    sida_dabble #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dabble (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(ch_valid[g]),
      .up_ready(ch_ready[g]),
      .up_neg  (ch_neg[g]),
      .up_mag  (ch_mag[g]),
      .up_bcd  (ch_bcd[g]),
      .dn_valid(ch_valid[g+1]),
      .dn_ready(ch_ready[g+1]),
      .dn_neg  (ch_neg[g+1]),
      .dn_mag  (ch_mag[g+1]),
      .dn_bcd  (ch_bcd[g+1])
    );
  end

  // serializer takes the finished digits; leftover magnitude bits are all zero
  sida_emit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld_valid     (ch_valid[VALUE_WIDTH]),
    .ld_ready     (ch_ready[VALUE_WIDTH]),
    .ld_neg       (ch_neg[VALUE_WIDTH]),
    .ld_bcd       (ch_bcd[VALUE_WIDTH]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

endmodule

/* rtl/sida_dabble.sv */
// one shift-and-add-3 step of the binary to bcd pipeline
module sida_dabble #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic                   up_neg,
  input  logic [VALUE_WIDTH-1:0] up_mag,
  input  logic [sida_pkg::digit_count(VALUE_WIDTH)*4-1:0] up_bcd,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic                   dn_neg,
  output logic [VALUE_WIDTH-1:0] dn_mag,
  output logic [sida_pkg::digit_count(VALUE_WIDTH)*4-1:0] dn_bcd
);

  localparam int NDig = sida_pkg::digit_count(VALUE_WIDTH);
  localparam int BcdW = NDig * 4;

  logic                   valid_r;
  logic                   valid_nxt;
  logic                   neg_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic [BcdW-1:0]        bcd_r;
  logic [BcdW-1:0]        adj;
  logic                   advance;

  assign advance  = !valid_r || dn_ready;
  assign up_ready = advance;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      if (up_bcd[i*4 +: 4] >= sida_pkg::BCD_ADJ_MIN) begin
        adj[i*4 +: 4] = up_bcd[i*4 +: 4] + sida_pkg::BCD_ADJ_ADD;
      end else begin
        adj[i*4 +: 4] = up_bcd[i*4 +: 4];
      end
    end
  end

  always_comb begin
    valid_nxt = advance ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      neg_r <= up_neg;
      mag_r <= {up_mag[VALUE_WIDTH-2:0], 1'b0};
      bcd_r <= {adj[BcdW-2:0], up_mag[VALUE_WIDTH-1]};
    end
  end

  assign dn_valid = valid_r;
  assign dn_neg   = neg_r;
  assign dn_mag   = mag_r;
  assign dn_bcd   = bcd_r;

endmodule

/* rtl/sida_emit.sv */
// character serializer with leading zero suppression and output register
module sida_emit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ld_valid,
  output logic                   ld_ready,
  input  logic                   ld_neg,
  input  logic [sida_pkg::digit_count(VALUE_WIDTH)*4-1:0] ld_bcd,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [sida_pkg::CodeW-1:0] out_char_code,
  output logic                   out_last_char
);

  localparam int NDig = sida_pkg::digit_count(VALUE_WIDTH);
  localparam int BcdW = NDig * 4;
  localparam int IdxW = (NDig > 1) ? $clog2(NDig) : 1;

  logic                        busy_r, busy_nxt;
  logic                        sign_r, sign_nxt;
  logic [IdxW-1:0]             pos_r, pos_nxt;
  logic [BcdW-1:0]             bcd_r, bcd_nxt;
  logic                        oval_r, oval_nxt;
  logic [sida_pkg::CodeW-1:0]  code_r, code_nxt;
  logic                        last_r, last_nxt;
  logic                        out_free;
  logic                        fin;
  logic                        ld_take;
  logic [IdxW-1:0]             top_dig;
  logic [3:0]                  cur_dig;

  assign out_free = !oval_r || !out_stall;
  assign fin      = busy_r && !sign_r && (pos_r == '0);
  assign ld_ready = !busy_r || (out_free && fin);
  assign ld_take  = ld_valid && ld_ready;
  assign cur_dig  = bcd_r[4*pos_r +: 4];

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    top_dig = '0;
    for (int i = 0; i < NDig; i++) begin
      if (ld_bcd[i*4 +: 4] != 4'd0) begin
        top_dig = IdxW'(i);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    sign_nxt = sign_r;
    pos_nxt  = pos_r;
    bcd_nxt  = bcd_r;
    oval_nxt = oval_r;
    code_nxt = code_r;
    last_nxt = last_r;
    if (out_free) begin
      oval_nxt = busy_r;
      code_nxt = sign_r ? sida_pkg::CODE_MINUS : (sida_pkg::CODE_ZERO + {3'b000, cur_dig});
      last_nxt = !sign_r && (pos_r == '0);
      if (busy_r) begin
        if (sign_r) begin
          sign_nxt = 1'b0;
        end else if (pos_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          pos_nxt = pos_r - 1'b1;
        end
      end
    end
    if (ld_take) begin
      busy_nxt = 1'b1;
      sign_nxt = ld_neg;
      pos_nxt  = top_dig;
      bcd_nxt  = ld_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sign_r <= sign_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    bcd_r  <= bcd_nxt;
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = oval_r;
  assign out_char_code = code_r;
  assign out_last_char = last_r;

`ifndef SYNTHESIS
  a_sign_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sign_r |-> busy_r)
    else $error("minus pending without an item in the serializer");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && code_r == sida_pkg::CODE_MINUS) |-> !last_r)
    else $error("minus sign flagged as last character");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && !out_stall && code_r == sida_pkg::CODE_MINUS)
      |=> (oval_r && code_r != sida_pkg::CODE_ZERO))
    else $error("minus not followed by a nonzero leading digit");

  a_load_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ld_take |=> busy_r)
    else $error("loaded item lost in the serializer");
`endif

endmodule
